// ----- sv/ukhm_pkg.sv -----
// ----------------------------------------------------------------------------
// ukhm_pkg: shared types and constants
// Widths, status codes, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package ukhm_pkg;

	localparam int Buckets     = 256;
	localparam int PoolEntries = 1024;
	localparam int BktW        = $clog2(Buckets);
	localparam int IdxW        = $clog2(PoolEntries);
	localparam int CntW        = IdxW + 1;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_MISSING   = 3'd4;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef struct packed {
		logic load;       // capture input beat, start hash
		logic hash_step;  // one hash round
		logic head_rd;    // read bucket head
		logic ent_rd;     // issue entry read at current pointer
		logic follow;     // advance pointer along link
		logic commit;     // write new entry and head
	} ukhm_cmd_t;

	typedef struct packed {
		logic       hash_done;
		logic       ptr_valid;
		logic       key_match;
		logic       pool_full;
		logic       walk_limit;
		logic       func;
	} ukhm_sts_t;

endpackage

// ----- sv/ukhm_in_if.sv -----
// ----------------------------------------------------------------------------
// ukhm_in_if: request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface ukhm_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] key;
	logic [31:0] value;
	modport source (output valid, func, key, value, input ready);
	modport sink (input valid, func, key, value, output ready);
endinterface

// ----- sv/ukhm_out_if.sv -----
// ----------------------------------------------------------------------------
// ukhm_out_if: response channel
// Valid/ready channel carrying one response beat.
// ----------------------------------------------------------------------------
interface ukhm_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] value_out;
	modport source (output valid, status, value_out, input ready);
	modport sink (input valid, status, value_out, output ready);
endinterface

// ----- sv/ukhm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ukhm_cfg_if: configuration write channel
// Valid/ready channel carrying the bucket_bits register value.
// ----------------------------------------------------------------------------
interface ukhm_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/ukhm_datapath.sv -----
// ----------------------------------------------------------------------------
// ukhm_datapath: hash unit, bucket heads and entry pool
// Iterative hash, head table with valid bits, pool memories and chain pointer.
// ----------------------------------------------------------------------------
module ukhm_datapath
	import ukhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ukhm_cmd_t   cmd,
	output ukhm_sts_t   sts,
	input  logic        in_func,
	input  logic [31:0] in_key,
	input  logic [31:0] in_value,
	input  logic [3:0]  bucket_bits,
	output logic [31:0] found_value
);

	logic              func_q;
	logic [31:0]       key_q;
	logic [31:0]       value_q;
	logic [31:0]       hash_q;
	logic [2:0]        round_q;
	logic [BktW-1:0]   bkt_q;
	logic [IdxW-1:0]   ptr_q;
	logic              ptr_valid_q;
	logic [CntW-1:0]   used_q;
	logic [CntW-1:0]   steps_q;
	logic [Buckets-1:0] head_valid_q;
	logic [IdxW-1:0]   head_mem [Buckets];
	logic [IdxW-1:0]   head_rd_q;
	logic [31:0]       key_mem  [PoolEntries];
	logic [31:0]       val_mem  [PoolEntries];
	logic [IdxW:0]     link_mem [PoolEntries];
	logic [31:0]       ent_key_q;
	logic [31:0]       ent_val_q;
	logic [IdxW:0]     ent_link_q;

	logic [31:0] byte_ext, h1, h2, h3, f1, f2;
	logic [15:0] mask;
	logic [BktW-1:0] bkt_d;

	// One round per cycle: four byte rounds, then the final mix.
	always_comb begin
		byte_ext = {{24{key_q[8*round_q[1:0]+7]}}, key_q[8*round_q[1:0] +: 8]};
		h1 = hash_q + byte_ext;
		h2 = h1 + (h1 << 10);
		h3 = h2 ^ (h2 >> 6);
		f1 = hash_q + (hash_q << 3);
		f2 = f1 ^ (f1 >> 11);
		mask = 16'((17'd1 << bucket_bits) - 17'd1);
		bkt_d = BktW'((f2 + (f2 << 15)) & {16'd0, mask});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q      <= '0;
			used_q       <= '0;
			head_valid_q <= '0;
			ptr_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				round_q <= '0;
			end else if (cmd.hash_step && round_q != 3'd5) begin
				round_q <= round_q + 3'd1;
			end
			if (cmd.head_rd) begin
				ptr_valid_q <= head_valid_q[bkt_q];
			end else if (cmd.follow) begin
				ptr_valid_q <= ent_link_q[IdxW];
			end
			if (cmd.commit) begin
				head_valid_q[bkt_q] <= 1'b1;
				used_q <= used_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= in_func;
			key_q   <= in_key;
			value_q <= in_value;
			hash_q  <= '0;
		end else if (cmd.hash_step) begin
			if (round_q < 3'd4) begin
				hash_q <= h3;
			end else if (round_q == 3'd4) begin
				bkt_q <= bkt_d;
			end
		end
		// The bucket does not change after the hash, so this still holds the
		// current head when the new entry is linked in.
		head_rd_q <= head_mem[bkt_q];
		if (cmd.head_rd) begin
			ptr_q   <= head_rd_q;
			steps_q <= '0;
		end else if (cmd.follow) begin
			ptr_q   <= ent_link_q[IdxW-1:0];
			steps_q <= steps_q + CntW'(1);
		end
		if (cmd.ent_rd) begin
			ent_key_q  <= key_mem[ptr_q];
			ent_val_q  <= val_mem[ptr_q];
			ent_link_q <= link_mem[ptr_q];
		end
		if (cmd.commit) begin
			head_mem[bkt_q] <= used_q[IdxW-1:0];
			key_mem[used_q[IdxW-1:0]]  <= key_q;
			val_mem[used_q[IdxW-1:0]]  <= value_q;
			link_mem[used_q[IdxW-1:0]] <= {head_valid_q[bkt_q], head_rd_q};
		end
	end

	assign sts.hash_done  = (round_q == 3'd5);
	assign sts.ptr_valid  = ptr_valid_q;
	assign sts.key_match  = (ent_key_q == key_q);
	assign sts.pool_full  = (used_q == CntW'(PoolEntries));
	assign sts.walk_limit = (steps_q == CntW'(PoolEntries));
	assign sts.func       = func_q;
	assign found_value    = ent_val_q;

endmodule

// ----- sv/ukhm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ukhm_ctrl: sequencing controller
// Steps hash, head read, chain walk and commit; holds the response register.
// ----------------------------------------------------------------------------
module ukhm_ctrl
	import ukhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	output logic [31:0] out_value,
	input  logic [31:0] found_value,
	input  ukhm_sts_t   sts,
	output ukhm_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_HASH, S_HEAD, S_HEAD2, S_RD, S_CHK, S_DONE
	} state_t;

	state_t     state_q;
	logic       out_valid_q;
	logic [2:0] status_q;
	logic [31:0] value_q;
	logic       in_acc;

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_status = status_q;
	assign out_value = value_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_acc;
		unique case (state_q)
			S_HASH:  cmd.hash_step = 1'b1;
			S_HEAD2: cmd.head_rd = 1'b1;
			S_RD:    cmd.ent_rd = 1'b1;
			S_CHK: begin
				if (!sts.key_match) begin
					cmd.follow = 1'b1;
				end
			end
			S_DONE: begin
				cmd.commit = (sts.func == FUNC_INSERT) && !sts.pool_full;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= ST_INSERTED;
			value_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (sts.hash_done) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD:  state_q <= S_HEAD2;
				S_HEAD2: state_q <= S_RD;
				S_RD: begin
					if (!sts.ptr_valid || sts.walk_limit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (sts.key_match) begin
						out_valid_q <= 1'b1;
						status_q <= (sts.func == FUNC_INSERT) ? ST_DUPLICATE : ST_FOUND;
						value_q  <= (sts.func == FUNC_INSERT) ? 32'd0 : found_value;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					value_q <= '0;
					if (sts.func == FUNC_LOOKUP) begin
						status_q <= ST_MISSING;
					end else if (sts.pool_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_INSERTED;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/uint32_key_hash_map_core.sv -----
// ----------------------------------------------------------------------------
// uint32_key_hash_map_core: chained hash map with 32-bit keys
// Insert and lookup of key/value pairs over a bucket table and entry pool.
// ----------------------------------------------------------------------------
// One request is handled at a time. Hashing runs one one-at-a-time round
// per cycle on each of the four sign-extended key bytes, then the final mix
// and bucket mask, then a step in which the controller sees the hash done.
// The registered bucket head is read through states S_HEAD and S_HEAD2, then
// each chain entry visited is read (S_RD) and compared (S_CHK) through the
// single read port of the entry pool. A key that is found is answered from
// its compare; a key that is absent needs one more read to reach the end of
// the chain and a final step to write back and post the response. The next
// request is taken once the response beat has been taken. Bucket heads
// carry valid bits that reset clears at once, so no clearing pass is needed.
// A new key is linked at the head of its chain; duplicates are rejected
// before the pool-full check. bucket_bits above 8 acts as 8.
// ----------------------------------------------------------------------------
module uint32_key_hash_map_core
	import ukhm_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	ukhm_cfg_if.sink cfg,
	ukhm_in_if.sink  req,
	ukhm_out_if.source rsp
);

	ukhm_cmd_t   cmd;
	ukhm_sts_t   sts;
	logic [31:0] found_value;
	logic [3:0]  bucket_bits_q;

	// Always ready, unchecked; user writes configuration register only while idle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_bits_q <= 4'd8;
		end else if (cfg.valid) begin
			bucket_bits_q <= cfg.data;
		end
	end

	ukhm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_value  (rsp.value_out),
		.found_value(found_value),
		.sts        (sts),
		.cmd        (cmd)
	);

	ukhm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_func    (req.func),
		.in_key     (req.key),
		.in_value   (req.value),
		.bucket_bits(bucket_bits_q > 4'd8 ? 4'd8 : bucket_bits_q),
		.found_value(found_value)
	);

endmodule
